FILE: rtl/core/sparse_column_partition_packer_defines.svh
// ----------------------------------------------------------------------------
// Sparse column partition packer: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPARSE_COLUMN_PARTITION_PACKER_DEFINES_SVH
`define SPARSE_COLUMN_PARTITION_PACKER_DEFINES_SVH

// Check cons in the same cycle as ante.
`define SCPP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scpp same-cycle check failed");

// Check cons in the cycle after ante.
`define SCPP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scpp next-cycle check failed");

`endif

FILE: rtl/core/scpp_pkg.sv
// ----------------------------------------------------------------------------
// Sparse column partition packer: package
// Payload structs, controller states and the command/status bundles.
// ----------------------------------------------------------------------------
package scpp_pkg;

    localparam logic ENTRY_KIND_DATA  = 1'b0;
    localparam logic ENTRY_KIND_FLUSH = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [31:0] row;
        logic [31:0] col;
        logic [15:0] value;
    } entry_t;

    typedef struct packed {
        logic [31:0] mem_row_number;
        logic [1:0]  slot;
        logic [2:0]  position;
        logic [31:0] row_out;
        logic [15:0] value_out;
        logic [31:0] slot_col;
        logic        slot_used;
        logic        last;
    } elem_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT,
        ST_COMMIT
    } scpp_state_t;

    typedef struct packed {
        logic capture;
        logic write;
        logic open_next;
        logic new_row;
        logic reset_all;
        logic emit_step;
    } scpp_cmd_t;

    typedef struct packed {
        logic is_flush;
        logic advance;
        logic wrap;
        logic emit_last;
        logic out_free;
    } scpp_status_t;

endpackage

FILE: rtl/core/scpp_ctrl.sv
// ----------------------------------------------------------------------------
// Sparse column partition packer: controller
// Sequences capture, slot decision, row emission and store update.
// ----------------------------------------------------------------------------
module scpp_ctrl
    import scpp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         entry_valid,
    output logic         entry_ready,
    input  scpp_status_t status,
    output scpp_cmd_t    cmd
);

    scpp_state_t state_reg;
    scpp_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (entry_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (status.is_flush || (status.advance && status.wrap))
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_EMIT:
            begin
                if (status.out_free && status.emit_last)
                begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        entry_ready = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                entry_ready = 1'b1;
                cmd.capture = entry_valid;
            end
            ST_EXEC:
            begin
                if (!(status.is_flush || (status.advance && status.wrap)))
                begin
                    cmd.write     = 1'b1;
                    cmd.open_next = status.advance;
                end
            end
            ST_EMIT:
            begin
                cmd.emit_step = status.out_free;
            end
            ST_COMMIT:
            begin
                if (status.is_flush)
                begin
                    cmd.reset_all = 1'b1;
                end
                else
                begin
                    cmd.write   = 1'b1;
                    cmd.new_row = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: rtl/core/scpp_dpath.sv
// ----------------------------------------------------------------------------
// Sparse column partition packer: datapath
// Place and column stores, packing pointers, emit counters, output register.
// ----------------------------------------------------------------------------
module scpp_dpath
    import scpp_pkg::*;
#(
    parameter int PART_DEPTH    = 8,
    parameter int SLOTS_PER_ROW = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  entry_t       entry,
    input  scpp_cmd_t    cmd,
    output scpp_status_t status,
    output logic         elem_valid,
    input  logic         elem_ready,
    output elem_t        elem
);

    localparam int PLACES = PART_DEPTH * SLOTS_PER_ROW;
    localparam int ADDR_W = (PLACES > 1) ? $clog2(PLACES) : 1;
    localparam int SLOT_W = (SLOTS_PER_ROW > 1) ? $clog2(SLOTS_PER_ROW) : 1;
    localparam int FILL_W = (PART_DEPTH > 1) ? $clog2(PART_DEPTH) : 1;
    localparam logic [SLOT_W-1:0] SlotLast = SLOT_W'(SLOTS_PER_ROW - 1);
    localparam logic [FILL_W-1:0] FillLast = FILL_W'(PART_DEPTH - 1);
    localparam logic [ADDR_W-1:0] AddrLast = ADDR_W'(PLACES - 1);

    // Payload stores (no reset; valid bits mask stale contents)
    logic [31:0] row_store_reg   [PLACES];
    logic [15:0] value_store_reg [PLACES];
    logic [31:0] col_store_reg   [SLOTS_PER_ROW];
    entry_t      item_reg;

    logic [PLACES-1:0]        place_vld_reg, place_vld_next;
    logic [SLOTS_PER_ROW-1:0] col_vld_reg, col_vld_next;
    logic [SLOT_W-1:0]        slot_idx_reg, slot_idx_next;
    logic [FILL_W-1:0]        fill_reg, fill_next;
    logic [31:0]              row_cnt_reg, row_cnt_next;
    logic                     open_reg, open_next;

    logic [SLOT_W-1:0]        e_slot_reg, e_slot_next;
    logic [FILL_W-1:0]        e_pos_reg, e_pos_next;
    logic [ADDR_W-1:0]        e_addr_reg, e_addr_next;

    elem_t                    elem_reg, elem_next;
    logic                     elem_vld_reg, elem_vld_next;

    logic [SLOT_W-1:0]        w_slot;
    logic [FILL_W-1:0]        w_fill;
    logic [ADDR_W-1:0]        w_addr;
    logic [31:0]              col_cur;
    logic [31:0]              e_col;

    // Status toward the controller
    assign col_cur = col_vld_reg[slot_idx_reg] ? col_store_reg[slot_idx_reg] : '0;

    assign status.is_flush  = (item_reg.kind == ENTRY_KIND_FLUSH);
    assign status.advance   = open_reg && ((fill_reg == '0) || (item_reg.col != col_cur));
    assign status.wrap      = (slot_idx_reg == SlotLast);
    assign status.emit_last = (e_addr_reg == AddrLast);
    assign status.out_free  = !elem_vld_reg || elem_ready;

    // Target place of the entry being written
    always_comb
    begin
        if (cmd.new_row)
        begin
            w_slot = '0;
            w_fill = '0;
        end
        else if (cmd.open_next)
        begin
            w_slot = slot_idx_reg + SLOT_W'(1);
            w_fill = '0;
        end
        else
        begin
            w_slot = slot_idx_reg;
            w_fill = fill_reg;
        end
        w_addr = ADDR_W'(int'(w_slot) * PART_DEPTH + int'(w_fill));
    end

    // Packing pointers and valid bits
    always_comb
    begin
        place_vld_next = place_vld_reg;
        col_vld_next   = col_vld_reg;
        slot_idx_next  = slot_idx_reg;
        fill_next      = fill_reg;
        row_cnt_next   = row_cnt_reg;
        open_next      = open_reg;
        if (cmd.reset_all)
        begin
            place_vld_next = '0;
            col_vld_next   = '0;
            slot_idx_next  = '0;
            fill_next      = '0;
            row_cnt_next   = '0;
            open_next      = 1'b0;
        end
        else if (cmd.write)
        begin
            if (cmd.new_row)
            begin
                place_vld_next = '0;
                col_vld_next   = '0;
                row_cnt_next   = row_cnt_reg + 32'd1;
            end
            place_vld_next[w_addr] = 1'b1;
            col_vld_next[w_slot]   = 1'b1;
            slot_idx_next          = w_slot;
            fill_next              = (w_fill == FillLast) ? '0 : w_fill + FILL_W'(1);
            open_next              = 1'b1;
        end
    end

    // Emit walk: slot-major, position-minor
    always_comb
    begin
        e_slot_next = e_slot_reg;
        e_pos_next  = e_pos_reg;
        e_addr_next = e_addr_reg;
        if (cmd.emit_step)
        begin
            if (e_addr_reg == AddrLast)
            begin
                e_slot_next = '0;
                e_pos_next  = '0;
                e_addr_next = '0;
            end
            else
            begin
                e_addr_next = e_addr_reg + ADDR_W'(1);
                if (e_pos_reg == FillLast)
                begin
                    e_pos_next  = '0;
                    e_slot_next = e_slot_reg + SLOT_W'(1);
                end
                else
                begin
                    e_pos_next = e_pos_reg + FILL_W'(1);
                end
            end
        end
    end

    assign e_col = col_vld_reg[e_slot_reg] ? col_store_reg[e_slot_reg] : '0;

    always_comb
    begin
        elem_next                = elem_reg;
        elem_vld_next            = elem_vld_reg && !elem_ready;
        if (cmd.emit_step)
        begin
            elem_vld_next            = 1'b1;
            elem_next.mem_row_number = row_cnt_reg;
            elem_next.slot           = 2'(e_slot_reg);
            elem_next.position       = 3'(e_pos_reg);
            elem_next.row_out        = place_vld_reg[e_addr_reg] ? row_store_reg[e_addr_reg]
                                                                 : '0;
            elem_next.value_out      = place_vld_reg[e_addr_reg] ? value_store_reg[e_addr_reg]
                                                                 : '0;
            elem_next.slot_col       = e_col;
            elem_next.slot_used      = (e_col != '0);
            elem_next.last           = (e_addr_reg == AddrLast);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            place_vld_reg <= '0;
            col_vld_reg   <= '0;
            slot_idx_reg  <= '0;
            fill_reg      <= '0;
            row_cnt_reg   <= '0;
            open_reg      <= 1'b0;
            e_slot_reg    <= '0;
            e_pos_reg     <= '0;
            e_addr_reg    <= '0;
            elem_vld_reg  <= 1'b0;
        end
        else
        begin
            place_vld_reg <= place_vld_next;
            col_vld_reg   <= col_vld_next;
            slot_idx_reg  <= slot_idx_next;
            fill_reg      <= fill_next;
            row_cnt_reg   <= row_cnt_next;
            open_reg      <= open_next;
            e_slot_reg    <= e_slot_next;
            e_pos_reg     <= e_pos_next;
            e_addr_reg    <= e_addr_next;
            elem_vld_reg  <= elem_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= entry;
        end
        if (cmd.write)
        begin
            row_store_reg[w_addr]   <= item_reg.row;
            value_store_reg[w_addr] <= item_reg.value;
            col_store_reg[w_slot]   <= item_reg.col;
        end
        elem_reg <= elem_next;
    end

    assign elem_valid = elem_vld_reg;
    assign elem       = elem_reg;

endmodule

FILE: rtl/core/sparse_column_partition_packer.sv
// ----------------------------------------------------------------------------
// Sparse column partition packer
// Sequence: each entry is captured in idle, then decided and stored; an entry
//   that finds the memory row full, or a flush, then emits SLOTS_PER_ROW*PART_DEPTH
//   elements, one per cycle through the output register when not stalled, and commits.
// Throughput: one entry per controller capture/store sequence, none taken
//   mid-sequence; a row burst is shared by the entries that filled the row.
// Reset: rst_n clears pointers, row counter and valid bits; every place reads zero.
// ----------------------------------------------------------------------------
module sparse_column_partition_packer
    import scpp_pkg::*;
#(
    parameter int PART_DEPTH    = 8,
    parameter int SLOTS_PER_ROW = 4
)
(
    input  logic   clk,
    input  logic   rst_n,
    // Entry channel: one sorted (row, col, value) entry or a flush per transfer
    input  logic   entry_valid,
    output logic   entry_ready,
    input  entry_t entry,
    // Element channel: one place of an emitted memory row per transfer
    output logic   elem_valid,
    input  logic   elem_ready,
    output elem_t  elem
);

    scpp_cmd_t    cmd;
    scpp_status_t status;

    // Controller: take an entry in idle, decide whether the slot advances,
    // run the row burst when the row is full or on a flush, then commit.
    scpp_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .status      (status),
        .cmd         (cmd)
    );

    // Datapath: hold the row being packed; the output register parts the
    // element burst from the entry side so the last element of a row can wait
    // downstream while packing resumes.
    scpp_dpath #(
        .PART_DEPTH    (PART_DEPTH),
        .SLOTS_PER_ROW (SLOTS_PER_ROW)
    ) u_dpath (
        .clk        (clk),
        .rst_n      (rst_n),
        .entry      (entry),
        .cmd        (cmd),
        .status     (status),
        .elem_valid (elem_valid),
        .elem_ready (elem_ready),
        .elem       (elem)
    );

endmodule

FILE: rtl/core/scpp_checker.sv
// ----------------------------------------------------------------------------
// Sparse column partition packer: port checker
// Watches the top-level ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
`include "sparse_column_partition_packer_defines.svh"

module scpp_checker
    import scpp_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   entry_valid,
    input logic   entry_ready,
    input entry_t entry,
    input logic   elem_valid,
    input logic   elem_ready,
    input elem_t  elem
);

    // A waiting entry holds.
    `SCPP_ASSERT_NEXT(a_entry_hold, entry_valid && !entry_ready, entry_valid && $stable(entry))

    // A stalled element holds.
    `SCPP_ASSERT_NEXT(a_elem_hold, elem_valid && !elem_ready, elem_valid && $stable(elem))

    // No entry is taken while a row burst is still in flight.
    `SCPP_ASSERT_NOW(a_burst_blocks_entry, elem_valid && !elem.last, !entry_ready)

    // Each entry transfer is followed by its decide and store step before the next.
    `SCPP_ASSERT_NEXT(a_entry_gap, entry_valid && entry_ready, !entry_ready)

endmodule

bind sparse_column_partition_packer scpp_checker u_scpp_checker (.*);
